// ===== hdl/trpft_pkg.sv =====
package trpft_pkg;

  localparam int unsigned OP_W      = 3;
  localparam int unsigned PAGE_W    = 10;
  localparam int unsigned OFFSET_W  = 12;
  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned RUN_OUT_W = 13;
  localparam int unsigned KIND_W    = 2;

  typedef enum logic [OP_W-1:0] {
    OP_MARK           = 3'd0,
    OP_COUNT_CACHED   = 3'd1,
    OP_COUNT_MISSING  = 3'd2,
    OP_INVALIDATE     = 3'd3,
    OP_CLEAR_PAGE     = 3'd4
  } op_t;

  localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CHANGED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DROPPED = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNUSED  = 2'd3;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_EXEC  = 2'd2
  } fsm_state_t;

endpackage

// ===== hdl/two_range_page_fill_tracker.sv =====
// Page fill tracker: each request reads one page entry (two filled ranges) from a
// synchronous page memory, updates it and writes it back. The memory read is
// registered when the request is taken; the update, write-back and loading of
// the result register follow in the update state. A new request is taken while
// a result still waits on out_stall; the update then holds until the result
// register frees. After reset a clearing pass empties every page, one per cycle,
// and in_stall stays high until it ends.
module two_range_page_fill_tracker #(
  parameter int unsigned PAGE_SAMPLES = 4096,
  parameter int unsigned NUM_PAGES    = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [trpft_pkg::OP_W-1:0]           in_operation,
  input  logic [trpft_pkg::PAGE_W-1:0]         in_page_index,
  input  logic [trpft_pkg::OFFSET_W-1:0]       in_offset,
  input  logic [trpft_pkg::COUNT_W-1:0]        in_span_count,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [trpft_pkg::RUN_OUT_W-1:0]      out_sample_run,
  output logic [trpft_pkg::KIND_W-1:0]         out_change_kind
);

  localparam int unsigned W  = $clog2(PAGE_SAMPLES + 1);
  localparam int unsigned AW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam logic [AW-1:0] CLR_END_IDX = AW'(NUM_PAGES - 1);

  logic [4*W-1:0] page_mem [NUM_PAGES];
  logic [4*W-1:0] rd_data_r;

  trpft_pkg::fsm_state_t state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;

  logic [trpft_pkg::OP_W-1:0]     op_r;
  logic [AW-1:0]                  page_r;
  logic [trpft_pkg::OFFSET_W-1:0] offset_r;
  logic [trpft_pkg::COUNT_W-1:0]  count_r;
  logic                           req_ok_r;

  logic                           out_valid_r, out_valid_nxt;
  logic [trpft_pkg::RUN_OUT_W-1:0] out_run_r;
  logic [trpft_pkg::KIND_W-1:0]   out_kind_r;

  logic in_acc;
  logic exec_fire;
  logic req_ok;

  logic [W-1:0] new_a0, new_a1, new_b0, new_b1, run;
  logic [trpft_pkg::KIND_W-1:0] kind;

  assign in_acc    = in_valid && !in_stall;
  assign exec_fire = (state_r == trpft_pkg::ST_EXEC) && (!out_valid_r || !out_stall);
  assign req_ok    = (32'(in_page_index) < 32'(NUM_PAGES)) &&
                     (32'(in_offset) < 32'(PAGE_SAMPLES));

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    in_stall    = 1'b1;
    unique case (state_r)
      trpft_pkg::ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == CLR_END_IDX) begin
          state_nxt = trpft_pkg::ST_IDLE;
        end
      end
      trpft_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = trpft_pkg::ST_EXEC;
        end
      end
      trpft_pkg::ST_EXEC: begin
        if (exec_fire) begin
          state_nxt = trpft_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = trpft_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= trpft_pkg::ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // page memory: one write port shared by the clearing pass and write-back
  always_ff @(posedge clk) begin
    if (state_r == trpft_pkg::ST_CLEAR) begin
      page_mem[clr_cnt_r] <= '0;
    end else if (exec_fire && req_ok_r) begin
      page_mem[page_r] <= {new_a0, new_a1, new_b0, new_b1};
    end
    if (in_acc) begin
      rd_data_r <= page_mem[AW'(in_page_index)];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r     <= in_operation;
      page_r   <= AW'(in_page_index);
      offset_r <= in_offset;
      count_r  <= in_span_count;
      req_ok_r <= req_ok;
    end
  end

  trpft_update #(
    .PAGE_SAMPLES (PAGE_SAMPLES)
  ) u_update (
    .req_ok     (req_ok_r),
    .operation  (op_r),
    .offset     (offset_r),
    .span_count (count_r),
    .a0         (rd_data_r[4*W-1:3*W]),
    .a1         (rd_data_r[3*W-1:2*W]),
    .b0         (rd_data_r[2*W-1:W]),
    .b1         (rd_data_r[W-1:0]),
    .new_a0     (new_a0),
    .new_a1     (new_a1),
    .new_b0     (new_b0),
    .new_b1     (new_b1),
    .run        (run),
    .kind       (kind)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (exec_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_run_r  <= trpft_pkg::RUN_OUT_W'(run);
      out_kind_r <= kind;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_sample_run  = out_run_r;
  assign out_change_kind = out_kind_r;

  a_acc_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == trpft_pkg::ST_EXEC))
    else $error("request not followed by update");

  a_out_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == trpft_pkg::ST_EXEC))
    else $error("result raised outside update");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_kind_r != trpft_pkg::KIND_UNUSED))
    else $error("illegal change kind");

  a_clear_ends: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == trpft_pkg::ST_CLEAR) && (clr_cnt_r == CLR_END_IDX))
      |=> (state_r == trpft_pkg::ST_IDLE))
    else $error("clearing pass overran");

endmodule

// ===== hdl/trpft_update.sv =====
module trpft_update #(
  parameter int unsigned PAGE_SAMPLES = 4096
) (
  input  logic                                  req_ok,
  input  logic [trpft_pkg::OP_W-1:0]            operation,
  input  logic [trpft_pkg::OFFSET_W-1:0]        offset,
  input  logic [trpft_pkg::COUNT_W-1:0]         span_count,
  input  logic [$clog2(PAGE_SAMPLES+1)-1:0]     a0,
  input  logic [$clog2(PAGE_SAMPLES+1)-1:0]     a1,
  input  logic [$clog2(PAGE_SAMPLES+1)-1:0]     b0,
  input  logic [$clog2(PAGE_SAMPLES+1)-1:0]     b1,
  output logic [$clog2(PAGE_SAMPLES+1)-1:0]     new_a0,
  output logic [$clog2(PAGE_SAMPLES+1)-1:0]     new_a1,
  output logic [$clog2(PAGE_SAMPLES+1)-1:0]     new_b0,
  output logic [$clog2(PAGE_SAMPLES+1)-1:0]     new_b1,
  output logic [$clog2(PAGE_SAMPLES+1)-1:0]     run,
  output logic [trpft_pkg::KIND_W-1:0]          kind
);

  localparam int unsigned W = $clog2(PAGE_SAMPLES + 1);
  localparam int unsigned SUM_W = trpft_pkg::COUNT_W + 1;
  localparam logic [W-1:0] PS_W = W'(PAGE_SAMPLES);

  function automatic logic [W-1:0] min_run(input logic [W-1:0] s,
                                           input logic [trpft_pkg::COUNT_W-1:0] cnt,
                                           input logic [W-1:0] lim);
    logic [SUM_W-1:0] sum;
    sum = {1'b0, cnt} + SUM_W'(s);
    if (sum < SUM_W'(lim)) begin
      return W'(cnt);
    end else begin
      return lim - s;
    end
  endfunction

  logic [W-1:0] s;
  logic [W-1:0] n;
  logic [W-1:0] e;
  logic         in_a;
  logic         in_b;

  always_comb begin
    s    = W'(offset);
    n    = min_run(s, span_count, PS_W);
    e    = s + n;
    in_a = (a0 <= s) && (a1 >= e);
    in_b = (b0 <= s) && (b1 >= e);

    new_a0 = a0;
    new_a1 = a1;
    new_b0 = b0;
    new_b1 = b1;
    run    = '0;
    kind   = trpft_pkg::KIND_NONE;

    if (req_ok) begin
      unique case (operation)
        trpft_pkg::OP_MARK: begin
          if (n != '0) begin
            run = n;
            if (!in_a && !in_b) begin
              kind = trpft_pkg::KIND_CHANGED;
              priority if (a1 == '0) begin
                new_a0 = s;
                new_a1 = e;
              end else if ((a0 <= e) && (a1 >= e)) begin
                new_a0 = s;
              end else if ((a0 <= s) && (a1 >= s)) begin
                new_a1 = e;
                if ((b0 != '0) && (e >= b0)) begin
                  new_a1 = b1;
                  new_b0 = '0;
                  new_b1 = '0;
                end
              end else if ((b0 != '0) && (b0 <= e) && (b1 >= e)) begin
                new_b0 = s;
              end else if ((b0 != '0) && (b0 <= s) && (b1 >= s)) begin
                new_b1 = e;
              end else begin
                if (b0 != '0) begin
                  kind = trpft_pkg::KIND_DROPPED;
                end
                if (a1 < s) begin
                  new_b0 = s;
                  new_b1 = e;
                end else begin
                  new_b0 = a0;
                  new_b1 = a1;
                  new_a0 = s;
                  new_a1 = e;
                end
              end
            end
          end
        end
        trpft_pkg::OP_COUNT_CACHED: begin
          priority if ((a0 <= s) && (a1 > s)) begin
            run = min_run(s, span_count, a1);
          end else if ((b0 <= s) && (b1 > s)) begin
            run = min_run(s, span_count, b1);
          end else begin
            run = '0;
          end
        end
        trpft_pkg::OP_COUNT_MISSING: begin
          priority if ((a0 <= s) && (a1 > s)) begin
            run = '0;
          end else if ((b0 <= s) && (b1 > s)) begin
            run = '0;
          end else if (a0 > s) begin
            run = min_run(s, span_count, a0);
          end else if (b0 > s) begin
            run = min_run(s, span_count, b0);
          end else if (b1 <= s) begin
            run = n;
          end else begin
            run = '0;
          end
        end
        trpft_pkg::OP_INVALIDATE: begin
          if (n != '0) begin
            run = n;
            if ((a0 != '0) && (s <= a0)) begin
              new_a0 = '0;
              new_a1 = '0;
              new_b0 = '0;
              new_b1 = '0;
            end else if (s < a1) begin
              new_a1 = s;
              new_b0 = '0;
              new_b1 = '0;
            end else if ((b0 != '0) && (s <= b0)) begin
              new_b0 = '0;
              new_b1 = '0;
            end else if (s < b1) begin
              new_b1 = s;
            end
          end
        end
        trpft_pkg::OP_CLEAR_PAGE: begin
          new_a0 = '0;
          new_a1 = '0;
          new_b0 = '0;
          new_b1 = '0;
        end
        default: begin
          run = '0;
        end
      endcase
    end
  end

endmodule

// ===== test/two_range_page_fill_tracker_tb.sv =====
`timescale 1ns / 100ps

module two_range_page_fill_tracker_tb;

  localparam int PAGE_SAMPLES    = 4096;
  localparam int NUM_PAGES       = 1024;
  localparam logic [trpft_pkg::OP_W-1:0] OP_CODE_MAX = '1;
  localparam int GRID            = 64;
  localparam int BUSY_PAGES      = 8;
  localparam int RANDOM_REQUESTS = 1000;
  localparam int MAX_GAP         = 10;
  localparam int MAX_REPORTED    = 10;
  localparam int STALL_LIMIT     = 5000;
  localparam int DRAIN_CYCLES    = 20;

  typedef struct {
    logic [trpft_pkg::OP_W-1:0]     op;
    logic [trpft_pkg::PAGE_W-1:0]   page;
    logic [trpft_pkg::OFFSET_W-1:0] offset;
    logic [trpft_pkg::COUNT_W-1:0]  count;
  } request_t;

  typedef struct {
    logic [trpft_pkg::RUN_OUT_W-1:0] run;
    logic [trpft_pkg::KIND_W-1:0]    kind;
  } fill_result_t;

  logic                                 clk = 1'b0;
  logic                                 rst_n = 1'b0;
  logic                                 in_valid = 1'b0;
  logic                                 in_stall;
  logic [trpft_pkg::OP_W-1:0]           in_operation = '0;
  logic [trpft_pkg::PAGE_W-1:0]         in_page_index = '0;
  logic [trpft_pkg::OFFSET_W-1:0]       in_offset = '0;
  logic [trpft_pkg::COUNT_W-1:0]        in_span_count = '0;
  logic                                 out_valid;
  logic                                 out_stall = 1'b0;
  logic [trpft_pkg::RUN_OUT_W-1:0]      out_sample_run;
  logic [trpft_pkg::KIND_W-1:0]         out_change_kind;

  longint unsigned seg_a_lo [NUM_PAGES];
  longint unsigned seg_a_hi [NUM_PAGES];
  longint unsigned seg_b_lo [NUM_PAGES];
  longint unsigned seg_b_hi [NUM_PAGES];

  request_t     pending_requests [$];
  fill_result_t awaited_results [$];
  request_t     in_flight;
  fill_result_t got_result;
  fill_result_t want_result;

  int total_requests;
  int accepted_requests = 0;
  int failures = 0;
  int idle_cycles = 0;
  int send_gap = 0;
  int take_gap = 0;
  bit send_eager = 1'b0;
  bit take_eager = 1'b0;

  two_range_page_fill_tracker #(
    .PAGE_SAMPLES(PAGE_SAMPLES),
    .NUM_PAGES(NUM_PAGES)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_operation(in_operation),
    .in_page_index(in_page_index),
    .in_offset(in_offset),
    .in_span_count(in_span_count),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_sample_run(out_sample_run),
    .out_change_kind(out_change_kind)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic longint unsigned clip_run(longint unsigned s, longint unsigned cnt,
                                               longint unsigned lim);
    return (s + cnt < lim) ? cnt : lim - s;
  endfunction

  function automatic logic [trpft_pkg::KIND_W-1:0] mark_filled(int unsigned pg,
                                                               longint unsigned s,
                                                               longint unsigned n);
    longint unsigned a0, a1, b0, b1, e;
    logic [trpft_pkg::KIND_W-1:0] kind;
    a0 = seg_a_lo[pg];
    a1 = seg_a_hi[pg];
    b0 = seg_b_lo[pg];
    b1 = seg_b_hi[pg];
    e = s + n;
    kind = trpft_pkg::KIND_CHANGED;
    if ((a0 <= s && a1 >= e) || (b0 <= s && b1 >= e)) return trpft_pkg::KIND_NONE;
    if (a1 == 0) begin
      a0 = s;
      a1 = e;
    end else if (a0 <= e && a1 >= e) begin
      a0 = s;
    end else if (a0 <= s && a1 >= s) begin
      a1 = e;
      // merge with B once A reaches it
      if (b0 != 0 && a1 >= b0) begin
        a1 = b1;
        b0 = 0;
        b1 = 0;
      end
    end else if (b0 != 0 && b0 <= e && b1 >= e) begin
      b0 = s;
    end else if (b0 != 0 && b0 <= s && b1 >= s) begin
      b1 = e;
    end else begin
      if (b0 != 0) kind = trpft_pkg::KIND_DROPPED;
      if (a1 < s) begin
        b0 = s;
        b1 = e;
      end else begin
        b0 = a0;
        b1 = a1;
        a0 = s;
        a1 = e;
      end
    end
    seg_a_lo[pg] = a0;
    seg_a_hi[pg] = a1;
    seg_b_lo[pg] = b0;
    seg_b_hi[pg] = b1;
    return kind;
  endfunction

  function automatic void cut_from(int unsigned pg, longint unsigned s);
    if (seg_a_lo[pg] != 0 && s <= seg_a_lo[pg]) begin
      seg_a_lo[pg] = 0;
      seg_a_hi[pg] = 0;
      seg_b_lo[pg] = 0;
      seg_b_hi[pg] = 0;
    end else if (s < seg_a_hi[pg]) begin
      seg_a_hi[pg] = s;
      seg_b_lo[pg] = 0;
      seg_b_hi[pg] = 0;
    end else if (seg_b_lo[pg] != 0 && s <= seg_b_lo[pg]) begin
      seg_b_lo[pg] = 0;
      seg_b_hi[pg] = 0;
    end else if (s < seg_b_hi[pg]) begin
      seg_b_hi[pg] = s;
    end
  endfunction

  function automatic fill_result_t track_request(request_t req);
    int unsigned pg;
    longint unsigned s, cnt, n, run, a0, a1, b0, b1;
    logic [trpft_pkg::KIND_W-1:0] kind;
    fill_result_t res;
    pg = 32'(req.page);
    s = 64'(req.offset);
    cnt = 64'(req.count);
    run = 0;
    kind = trpft_pkg::KIND_NONE;
    if (pg < NUM_PAGES && s < PAGE_SAMPLES) begin
      n = clip_run(s, cnt, PAGE_SAMPLES);
      a0 = seg_a_lo[pg];
      a1 = seg_a_hi[pg];
      b0 = seg_b_lo[pg];
      b1 = seg_b_hi[pg];
      case (req.op)
        trpft_pkg::OP_MARK: begin
          if (n != 0) begin
            kind = mark_filled(pg, s, n);
            run = n;
          end
        end
        trpft_pkg::OP_COUNT_CACHED: begin
          if (a0 <= s && a1 > s) run = clip_run(s, cnt, a1);
          else if (b0 <= s && b1 > s) run = clip_run(s, cnt, b1);
        end
        trpft_pkg::OP_COUNT_MISSING: begin
          if (a0 <= s && a1 > s) run = 0;
          else if (b0 <= s && b1 > s) run = 0;
          else if (a0 > s) run = clip_run(s, cnt, a0);
          else if (b0 > s) run = clip_run(s, cnt, b0);
          else if (b1 <= s) run = n;
        end
        trpft_pkg::OP_INVALIDATE: begin
          if (n != 0) begin
            cut_from(pg, s);
            run = n;
          end
        end
        trpft_pkg::OP_CLEAR_PAGE: begin
          seg_a_lo[pg] = 0;
          seg_a_hi[pg] = 0;
          seg_b_lo[pg] = 0;
          seg_b_hi[pg] = 0;
        end
        default: ;
      endcase
    end
    res.run = run[trpft_pkg::RUN_OUT_W-1:0];
    res.kind = kind;
    return res;
  endfunction

  function automatic void push_request(logic [trpft_pkg::OP_W-1:0] op, int unsigned page,
                                       int unsigned offset,
                                       logic [trpft_pkg::COUNT_W-1:0] count);
    request_t req;
    req.op = op;
    req.page = trpft_pkg::PAGE_W'(page);
    req.offset = trpft_pkg::OFFSET_W'(offset);
    req.count = count;
    pending_requests.push_back(req);
  endfunction

  // a point close to a multiple of the grid, so that spans meet and overlap often
  function automatic int unsigned near_grid(int steps, int top);
    int v;
    v = steps * GRID + $urandom_range(0, 2) - 1;
    if (v < 0) v = 0;
    if (v > top) v = top;
    return v;
  endfunction

  function automatic int draw_gap(bit eager);
    return eager ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  function automatic void flag_failure(string what);
    failures++;
    if (failures <= MAX_REPORTED) $display("%s", what);
  endfunction

  function automatic void build_directed();
    push_request(trpft_pkg::OP_COUNT_MISSING, 0, 0, '1);
    push_request(trpft_pkg::OP_MARK, 3, 100, 0);
    push_request(trpft_pkg::OP_MARK, 3, 100, 100);
    push_request(trpft_pkg::OP_MARK, 3, 120, 50);
    push_request(trpft_pkg::OP_MARK, 3, 50, 60);
    push_request(trpft_pkg::OP_MARK, 3, 200, 50);
    push_request(trpft_pkg::OP_MARK, 3, 400, 100);
    push_request(trpft_pkg::OP_MARK, 3, 350, 60);
    push_request(trpft_pkg::OP_MARK, 3, 500, 20);
    push_request(trpft_pkg::OP_COUNT_CACHED, 3, 60, '1);
    push_request(trpft_pkg::OP_COUNT_MISSING, 3, 250, 1000);
    push_request(trpft_pkg::OP_MARK, 3, 240, 120);
    push_request(trpft_pkg::OP_MARK, 3, 1000, 10);
    push_request(trpft_pkg::OP_MARK, 3, 2000, 10);
    push_request(trpft_pkg::OP_MARK, 3, 10, 20);
    push_request(trpft_pkg::OP_INVALIDATE, 3, 25, 0);
    push_request(trpft_pkg::OP_INVALIDATE, 3, 25, 5);
    push_request(trpft_pkg::OP_MARK, 3, PAGE_SAMPLES - 1, '1);
    push_request(trpft_pkg::OP_INVALIDATE, 3, PAGE_SAMPLES - 1, 1);
    push_request(trpft_pkg::OP_INVALIDATE, 3, 0, 1);
    push_request(trpft_pkg::OP_MARK, NUM_PAGES - 1, 0, '1);
    push_request(trpft_pkg::OP_COUNT_CACHED, NUM_PAGES - 1, PAGE_SAMPLES - 1, 5);
    push_request(trpft_pkg::OP_INVALIDATE, NUM_PAGES - 1, 0, '1);
    push_request(trpft_pkg::OP_CLEAR_PAGE, 3, PAGE_SAMPLES - 1, '1);
    push_request(OP_CODE_MAX, 3, 0, '1);
    push_request(trpft_pkg::OP_W'(trpft_pkg::OP_CLEAR_PAGE + 1), NUM_PAGES - 1, 100, 100);
  endfunction

  function automatic void build_random();
    int counted;
    int pick;
    logic [trpft_pkg::OP_W-1:0] op;
    int unsigned page, offset;
    logic [trpft_pkg::COUNT_W-1:0] count;
    counted = 0;
    while (counted < RANDOM_REQUESTS) begin
      pick = $urandom_range(0, 99);
      if (pick < 46) op = trpft_pkg::OP_MARK;
      else if (pick < 61) op = trpft_pkg::OP_COUNT_CACHED;
      else if (pick < 76) op = trpft_pkg::OP_COUNT_MISSING;
      else if (pick < 89) op = trpft_pkg::OP_INVALIDATE;
      else if (pick < 95) op = trpft_pkg::OP_CLEAR_PAGE;
      else op = trpft_pkg::OP_W'($urandom_range(trpft_pkg::OP_CLEAR_PAGE + 1, OP_CODE_MAX));
      page = ($urandom_range(0, 9) != 0) ? $urandom_range(0, BUSY_PAGES - 1)
                                         : $urandom_range(0, NUM_PAGES - 1);
      offset = ($urandom_range(0, 3) != 0) ?
               near_grid($urandom_range(0, PAGE_SAMPLES / GRID - 1), PAGE_SAMPLES - 1) :
               $urandom_range(0, PAGE_SAMPLES - 1);
      pick = $urandom_range(0, 9);
      if (pick < 7) count = near_grid($urandom_range(0, 8), PAGE_SAMPLES);
      else if (pick == 7) count = 0;
      else if (pick == 8) count = $urandom;
      else count = $urandom_range(1, PAGE_SAMPLES);
      push_request(op, page, offset, count);
      if (op <= trpft_pkg::OP_CLEAR_PAGE) counted++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        awaited_results.push_back(track_request(in_flight));
        accepted_requests++;
      end
      if (send_gap != 0 || pending_requests.size() == 0) begin
        if (send_gap != 0) send_gap--;
        in_valid <= 1'b0;
      end else begin
        in_flight = pending_requests.pop_front();
        in_operation <= in_flight.op;
        in_page_index <= in_flight.page;
        in_offset <= in_flight.offset;
        in_span_count <= in_flight.count;
        in_valid <= 1'b1;
        if ($urandom_range(0, 39) == 0) send_eager = !send_eager;
        send_gap = draw_gap(send_eager);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      take_gap = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got_result.run = out_sample_run;
        got_result.kind = out_change_kind;
        if (awaited_results.size() == 0) begin
          flag_failure($sformatf("unexpected result: sample_run %0d, change_kind %0d",
                                 got_result.run, got_result.kind));
        end else begin
          want_result = awaited_results.pop_front();
          if (got_result.run !== want_result.run)
            flag_failure($sformatf("sample_run mismatch: expected %0d, got %0d",
                                   want_result.run, got_result.run));
          if (got_result.kind !== want_result.kind)
            flag_failure($sformatf("change_kind mismatch: expected %0d, got %0d",
                                   want_result.kind, got_result.kind));
        end
        if ($urandom_range(0, 39) == 0) take_eager = !take_eager;
        take_gap = draw_gap(take_eager);
      end
      if (take_gap != 0) begin
        take_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    build_directed();
    build_random();
    total_requests = pending_requests.size();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    while (accepted_requests < total_requests || awaited_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/trpft_pkg.sv
hdl/trpft_update.sv
hdl/two_range_page_fill_tracker.sv
test/two_range_page_fill_tracker_tb.sv
